### sv/ava_pkg.sv
// Shared types and constants for the audio voice allocator.
// No dependencies; imported by the allocator, its RAM user and the checker.
package ava_pkg;

  localparam int DEF_NUM_VOICES = 8;
  localparam int DEF_NUM_TYPES  = 8;

  localparam int CNT_W   = 8;   // voice counts, range bounds, reservation sums
  localparam int RES_W   = 4;   // one reservation field
  localparam int PRIO_W  = 8;
  localparam int TYPE_W  = 3;
  localparam int VOICE_W = 3;   // width of the voice ports
  localparam int CFG_W   = 32;
  localparam int ADDR_W  = 3;

  localparam logic       FUNC_ALLOC    = 1'b0;
  localparam logic       FUNC_RELEASE  = 1'b1;
  localparam logic [0:0] REG_RESERVED  = 1'b0;   // register index, paddr[2]

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_SETUP,
    ST_SCAN,
    ST_FIN
  } st_t;

endpackage

### sv/ava_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ava_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/audio_voice_allocator.sv
// Top level of the audio voice allocator: sequencer, voice busy flags, config register.
// Depends on ava_pkg and ava_ram (voice priority and type store).
//
// Usage: an item is taken when start is high and busy is low. A release item
// (in_func = 1) frees one voice and its all-zero result appears on the cycle
// after the transfer; busy never rises for it. An allocate item keeps busy high
// while a small sequencer runs: it adds up the reservation fields one type
// after another with one shared adder, forms the search range, reads the
// voices of that range from the voice store and judges each one when its
// registered read data arrives (the scan stops at the first free voice), and
// finally commits the result. The scan goes one voice per cycle over the
// store's single read port. Each result is shown for exactly one cycle with
// out_valid high; there is no backpressure, so the receiver must take it
// then. reserved_counts is written over the APB port at address 0; the user
// must write it only while the block is idle, which the block itself does not
// enforce. pready is tied high.
module audio_voice_allocator #(
  parameter int NUM_VOICES = ava_pkg::DEF_NUM_VOICES,
  parameter int NUM_TYPES  = ava_pkg::DEF_NUM_TYPES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_func,
  input  logic [ava_pkg::TYPE_W-1:0]  in_clip_type,
  input  logic [ava_pkg::PRIO_W-1:0]  in_request_priority,
  input  logic                        in_interrupt_equal,
  input  logic [ava_pkg::VOICE_W-1:0] in_release_voice,
  // result channel
  output logic                        out_valid,
  output logic                        out_granted,
  output logic [ava_pkg::VOICE_W-1:0] out_voice,
  output logic                        out_stolen,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ava_pkg::ADDR_W-1:0]  paddr,
  input  logic [ava_pkg::CFG_W-1:0]   pwdata,
  output logic [ava_pkg::CFG_W-1:0]   prdata,
  output logic                        pready
);
  import ava_pkg::*;

  localparam int VW = $clog2(NUM_VOICES);
  localparam int XW = (VW > VOICE_W) ? VW : VOICE_W;   // common index width
  localparam int MW = PRIO_W + TYPE_W;                 // store word: {prio, type}

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] cfg_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_RESERVED)) begin
      cfg_r <= pwdata;
    end
  end

  assign prdata = (paddr[2] == REG_RESERVED) ? cfg_r : '0;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  st_t                 state_r, state_nxt;
  logic [NUM_VOICES-1:0] vbusy_r, vbusy_nxt;     // per-voice busy flags

  // latched request
  logic [TYPE_W-1:0]   ctype_r, ctype_nxt;
  logic [PRIO_W-1:0]   prio_r, prio_nxt;
  logic                ieq_r, ieq_nxt;

  // reservation summation
  logic [TYPE_W-1:0]   tc_r, tc_nxt;            // type under summation
  logic [CNT_W-1:0]    pre_r, pre_nxt;          // sum over types below ctype
  logic [CNT_W-1:0]    tot_r, tot_nxt;          // sum over all types
  logic [RES_W-1:0]    own_r, own_nxt;          // reservation of ctype

  // scan
  logic [CNT_W-1:0]    idx_r, idx_nxt;          // next address to read
  logic [CNT_W-1:0]    end_r, end_nxt;          // one past last voice of range
  logic                pv_r, pv_nxt;            // read data in flight is valid
  logic [VW-1:0]       pidx_r, pidx_nxt;        // voice whose data is arriving
  logic                found_r, found_nxt;      // free voice found
  logic [VW-1:0]       chosen_r, chosen_nxt;
  logic                have_low_r, have_low_nxt;
  logic [PRIO_W-1:0]   low_prio_r, low_prio_nxt;
  logic [VW-1:0]       low_id_r, low_id_nxt;

  // result registers
  logic                out_valid_r, out_valid_nxt;
  logic                out_granted_r, out_granted_nxt;
  logic [VOICE_W-1:0]  out_voice_r, out_voice_nxt;
  logic                out_stolen_r, out_stolen_nxt;

  // voice store
  logic                ram_we;
  logic [VW-1:0]       ram_waddr;
  logic [MW-1:0]       ram_wdata;
  logic [MW-1:0]       ram_rdata;
  logic [PRIO_W-1:0]   rd_prio;
  logic [TYPE_W-1:0]   rd_type;

  ava_ram #(
    .WIDTH (MW),
    .DEPTH (NUM_VOICES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r[VW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_prio = ram_rdata[MW-1:TYPE_W];
  assign rd_type = ram_rdata[TYPE_W-1:0];

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vbusy_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vbusy_r     <= vbusy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ctype_r       <= ctype_nxt;
    prio_r        <= prio_nxt;
    ieq_r         <= ieq_nxt;
    tc_r          <= tc_nxt;
    pre_r         <= pre_nxt;
    tot_r         <= tot_nxt;
    own_r         <= own_nxt;
    idx_r         <= idx_nxt;
    end_r         <= end_nxt;
    pv_r          <= pv_nxt;
    pidx_r        <= pidx_nxt;
    found_r       <= found_nxt;
    chosen_r      <= chosen_nxt;
    have_low_r    <= have_low_nxt;
    low_prio_r    <= low_prio_nxt;
    low_id_r      <= low_id_nxt;
    out_granted_r <= out_granted_nxt;
    out_voice_r   <= out_voice_nxt;
    out_stolen_r  <= out_stolen_nxt;
  end

  assign busy        = (state_r != ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_granted = out_granted_r;
  assign out_voice   = out_voice_r;
  assign out_stolen  = out_stolen_r;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic [RES_W-1:0] res_cur;      // reservation field of type tc_r
  logic [CNT_W-1:0] sum_a;        // shared adder operand
  logic [CNT_W-1:0] sum_b;
  logic [CNT_W-1:0] sum_y;
  logic [XW-1:0]    rel_ext;
  logic [XW-1:0]    pick_ext;
  logic             steal_ok;
  logic [VW-1:0]    pick;

  assign res_cur  = cfg_r[{tc_r, 2'b00} +: RES_W];
  assign rel_ext  = XW'(in_release_voice);
  assign pick     = found_r ? chosen_r : low_id_r;
  assign pick_ext = XW'(pick);
  // without the equal-interrupt flag the request must be strictly higher
  assign steal_ok = have_low_r && (ieq_r ? (low_prio_r <= prio_r) : (low_prio_r < prio_r));

  always_comb begin
    state_nxt       = state_r;
    vbusy_nxt       = vbusy_r;
    ctype_nxt       = ctype_r;
    prio_nxt        = prio_r;
    ieq_nxt         = ieq_r;
    tc_nxt          = tc_r;
    pre_nxt         = pre_r;
    tot_nxt         = tot_r;
    own_nxt         = own_r;
    idx_nxt         = idx_r;
    end_nxt         = end_r;
    pv_nxt          = pv_r;
    pidx_nxt        = pidx_r;
    found_nxt       = found_r;
    chosen_nxt      = chosen_r;
    have_low_nxt    = have_low_r;
    low_prio_nxt    = low_prio_r;
    low_id_nxt      = low_id_r;
    out_valid_nxt   = 1'b0;
    out_granted_nxt = out_granted_r;
    out_voice_nxt   = out_voice_r;
    out_stolen_nxt  = out_stolen_r;
    ram_we          = 1'b0;
    ram_waddr       = pick;
    ram_wdata       = {prio_r, ctype_r};
    sum_a           = '0;
    sum_b           = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_func == FUNC_RELEASE) begin
            // voices past the last are ignored
            if (CNT_W'(in_release_voice) < CNT_W'(NUM_VOICES)) begin
              vbusy_nxt[rel_ext[VW-1:0]] = 1'b0;
            end
            out_valid_nxt   = 1'b1;
            out_granted_nxt = 1'b0;
            out_voice_nxt   = '0;
            out_stolen_nxt  = 1'b0;
          end else begin
            ctype_nxt = in_clip_type;
            prio_nxt  = in_request_priority;
            ieq_nxt   = in_interrupt_equal;
            tc_nxt    = '0;
            pre_nxt   = '0;
            tot_nxt   = '0;
            own_nxt   = '0;
            state_nxt = ST_SUM;
          end
        end
      end

      ST_SUM: begin
        // one reservation field per cycle through the shared adder
        sum_a   = tot_r;
        sum_b   = CNT_W'(res_cur);
        tot_nxt = sum_y;
        if (tc_r == ctype_r) begin
          pre_nxt = tot_r;   // running total holds the fields below ctype here
          own_nxt = res_cur;
        end
        tc_nxt = tc_r + 1'b1;
        if (tc_r == TYPE_W'(NUM_TYPES - 1)) begin
          state_nxt = ST_SETUP;
        end
      end

      ST_SETUP: begin
        // reserved type: own range; else the shared pool above all reservations
        if (own_r != '0) begin
          sum_a   = pre_r;
          sum_b   = CNT_W'(own_r);
          idx_nxt = pre_r;
          end_nxt = (sum_y > CNT_W'(NUM_VOICES)) ? CNT_W'(NUM_VOICES) : sum_y;
        end else begin
          idx_nxt = tot_r;
          end_nxt = CNT_W'(NUM_VOICES);
        end
        pv_nxt       = 1'b0;
        found_nxt    = 1'b0;
        have_low_nxt = 1'b0;
        state_nxt    = ST_SCAN;
      end

      ST_SCAN: begin
        // issue read of idx_r while judging the voice read last cycle
        if (idx_r < end_r) begin
          pv_nxt   = 1'b1;
          pidx_nxt = idx_r[VW-1:0];
          sum_a    = idx_r;
          sum_b    = CNT_W'(1);
          idx_nxt  = sum_y;
        end else begin
          pv_nxt = 1'b0;
          if (!pv_r) begin
            state_nxt = ST_FIN;
          end
        end
        if (pv_r) begin
          if (!vbusy_r[pidx_r]) begin
            found_nxt  = 1'b1;
            chosen_nxt = pidx_r;
            pv_nxt     = 1'b0;
            state_nxt  = ST_FIN;
          end else if (rd_type == ctype_r && (!have_low_r || rd_prio < low_prio_r)) begin
            have_low_nxt = 1'b1;
            low_prio_nxt = rd_prio;
            low_id_nxt   = pidx_r;
          end
        end
      end

      ST_FIN: begin
        out_valid_nxt = 1'b1;
        if (found_r || steal_ok) begin
          ram_we          = 1'b1;
          vbusy_nxt[pick] = 1'b1;
          out_granted_nxt = 1'b1;
          out_voice_nxt   = pick_ext[VOICE_W-1:0];
          out_stolen_nxt  = !found_r;
        end else begin
          out_granted_nxt = 1'b0;
          out_voice_nxt   = '0;
          out_stolen_nxt  = 1'b0;
        end
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign sum_y = sum_a + sum_b;

endmodule

### sv/ava_checker.sv
// Port-level checker for the audio voice allocator, bound to the top level.
// Depends on ava_pkg and audio_voice_allocator.
module ava_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        in_func,
  input logic                        out_valid,
  input logic                        out_granted,
  input logic [ava_pkg::VOICE_W-1:0] out_voice,
  input logic                        out_stolen
);
  import ava_pkg::*;

  // a release transfer gives its empty result on the next cycle
  a_release_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_func == FUNC_RELEASE |=> out_valid && !out_granted)
    else $error("release result missing or granted");

  // an allocate transfer occupies the block
  a_alloc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_func == FUNC_ALLOC |=> busy && !out_valid)
    else $error("allocate did not hold busy");

  // a refused result carries no voice and no steal
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_granted |-> out_voice == '0 && !out_stolen)
    else $error("refused result with nonzero fields");

  // the block is free after a result unless a new allocate came in
  a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !start |=> !busy)
    else $error("busy after result without a new transfer");

endmodule

bind audio_voice_allocator ava_checker u_ava_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .in_func     (in_func),
  .out_valid   (out_valid),
  .out_granted (out_granted),
  .out_voice   (out_voice),
  .out_stolen  (out_stolen)
);

### test/testbench.sv
// Self-checking testbench for audio_voice_allocator: directed and random voice traffic.
// Depends on ava_pkg and the allocator RTL; holds its own allocation predictor.
`timescale 1ns / 100ps

module testbench;
  import ava_pkg::*;

  localparam int NV     = DEF_NUM_VOICES;
  localparam int NT     = DEF_NUM_TYPES;
  localparam int SETTLE = 30;   // settling margin, longer than the slowest allocate
  localparam int MAX_REPORTS = 10;
  localparam logic [ADDR_W-1:0] ADDR_RESERVED = {REG_RESERVED, 2'b00};

  // one result transfer
  typedef struct packed {
    logic               granted;
    logic [VOICE_W-1:0] voice;
    logic               stolen;
  } grant_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                in_func;
  logic [TYPE_W-1:0]   in_clip_type;
  logic [PRIO_W-1:0]   in_request_priority;
  logic                in_interrupt_equal;
  logic [VOICE_W-1:0]  in_release_voice;
  logic                out_valid;
  logic                out_granted;
  logic [VOICE_W-1:0]  out_voice;
  logic                out_stolen;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [CFG_W-1:0]    pwdata;
  logic [CFG_W-1:0]    prdata;
  logic                pready;

  audio_voice_allocator DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_func             (in_func),
    .in_clip_type        (in_clip_type),
    .in_request_priority (in_request_priority),
    .in_interrupt_equal  (in_interrupt_equal),
    .in_release_voice    (in_release_voice),
    .out_valid           (out_valid),
    .out_granted         (out_granted),
    .out_voice           (out_voice),
    .out_stolen          (out_stolen),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  // Predictor state: a copy of the voice table and the reservation register.
  logic [CFG_W-1:0]  reserve_reg;
  logic              voice_in_use [NV];
  logic [PRIO_W-1:0] voice_prio   [NV];
  logic [TYPE_W-1:0] voice_kind   [NV];

  grant_t expected_grants [$];   // results still owed by the block, oldest first

  int errors;
  int send_idle_pct;             // chance in percent of an idle cycle before each item
  int n_granted, n_stolen, n_refused, n_released, n_settings;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs (far beyond the slowest correct run).
  initial begin
    #5_000_000;
    $display("testbench: errors");
    $finish;
  end

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t ns  mismatch: %s", $time, msg);
  endtask

  function automatic int reserve_of(input int t);
    if (t >= NT) return 0;
    return int'(reserve_reg[RES_W*t +: RES_W]);
  endfunction

  // Works out the result of one accepted item and updates the voice table.
  function automatic grant_t predict_grant(input logic func,
                                           input logic [TYPE_W-1:0]  ctype,
                                           input logic [PRIO_W-1:0]  prio,
                                           input logic               ieq,
                                           input logic [VOICE_W-1:0] rel);
    grant_t g;
    int     first, last, eff, low_prio, low_id, pick;
    bit     found, have_low;
    g        = '0;
    found    = 0;
    have_low = 0;
    low_prio = 0;
    low_id   = 0;
    pick     = 0;
    if (func == FUNC_RELEASE) begin
      if (int'(rel) < NV) voice_in_use[rel] = 1'b0;   // idle voice just stays idle
      n_released++;
      return g;
    end
    // own range for a reserved type, else the shared pool after all reservations
    first = 0;
    if (reserve_of(ctype) > 0) begin
      for (int t = 0; t < int'(ctype); t++) first += reserve_of(t);
      last = first + reserve_of(ctype);
    end else begin
      for (int t = 0; t < NT; t++) first += reserve_of(t);
      last = NV;
    end
    if (last > NV) last = NV;
    // without the equal flag a tie cannot be stolen; prio 0 then steals nothing
    eff = ieq ? int'(prio) : int'(prio) - 1;
    for (int i = first; i < last; i++) begin
      if (!voice_in_use[i]) begin
        found = 1;
        pick  = i;
        break;
      end
      if (voice_kind[i] == ctype && (!have_low || int'(voice_prio[i]) < low_prio)) begin
        have_low = 1;
        low_prio = int'(voice_prio[i]);
        low_id   = i;
      end
    end
    if (!found) begin
      if (have_low && low_prio <= eff) begin
        pick     = low_id;
        g.stolen = 1'b1;
        n_stolen++;
      end else begin
        n_refused++;
        return g;
      end
    end
    voice_in_use[pick] = 1'b1;
    voice_prio[pick]   = prio;
    voice_kind[pick]   = ctype;
    g.granted = 1'b1;
    g.voice   = pick[VOICE_W-1:0];
    n_granted++;
    return g;
  endfunction

  // Sends one item; returns at the edge of its transfer with start still high.
  // busy is sampled at the falling edge, where it is stable for the next rising one.
  task automatic send_item(input logic func, input logic [TYPE_W-1:0] ctype,
                           input logic [PRIO_W-1:0] prio, input logic ieq,
                           input logic [VOICE_W-1:0] rel);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start               <= 1'b1;
    in_func             <= func;
    in_clip_type        <= ctype;
    in_request_priority <= prio;
    in_interrupt_equal  <= ieq;
    in_release_voice    <= rel;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    expected_grants.push_back(predict_grant(func, ctype, prio, ieq, rel));
  endtask

  task automatic send_alloc(input int ctype, input int prio, input bit ieq);
    send_item(FUNC_ALLOC, ctype[TYPE_W-1:0], prio[PRIO_W-1:0], ieq,
              VOICE_W'($urandom_range(NV-1)));
  endtask

  task automatic send_release(input int v);
    send_item(FUNC_RELEASE, TYPE_W'($urandom_range(NT-1)), PRIO_W'($urandom()),
              1'($urandom()), v[VOICE_W-1:0]);
  endtask

  // Stops sending and waits until every owed result has come and the block is quiet.
  task automatic wait_idle();
    start <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // APB write of the reservation register followed by a read-back check.
  task automatic write_reserved(input logic [CFG_W-1:0] value);
    bit                ready;
    logic [CFG_W-1:0]  got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_RESERVED;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      ready = pready;
      @(posedge clk);
    end while (!ready);
    reserve_reg = value;
    n_settings++;
    // back-to-back read transfer
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      ready = pready;
      got   = prdata;
      @(posedge clk);
    end while (!ready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== value)
      flag_error($sformatf("reserved_counts read back %h, expected %h", got, value));
  endtask

  // Result checker: out_valid lasts one full cycle, so the falling edge sees it once.
  always @(negedge clk) begin : check_results
    grant_t want;
    if (rst_n && out_valid) begin
      if (expected_grants.size() == 0) begin
        flag_error($sformatf("result with none owed: granted %b voice %0d stolen %b",
                             out_granted, out_voice, out_stolen));
      end else begin
        want = expected_grants.pop_front();
        if (out_granted !== want.granted)
          flag_error($sformatf("granted: expected %b, got %b", want.granted, out_granted));
        if (out_voice !== want.voice)
          flag_error($sformatf("voice: expected %0d, got %0d", want.voice, out_voice));
        if (out_stolen !== want.stolen)
          flag_error($sformatf("stolen: expected %b, got %b", want.stolen, out_stolen));
      end
    end
  end

  // Reset reservations: every type shares all eight voices. Fill the pool, then
  // probe stealing around ties, zero priority, release of an idle voice.
  task automatic test_shared_pool();
    int prios [8] = '{255, 0, 10, 10, 128, 1, 10, 200};
    for (int i = 0; i < NV; i++) send_alloc(i, prios[i], i[0]);
    send_alloc(2, 10, 1'b0);    // tie without the equal flag: refused
    send_alloc(2, 10, 1'b1);    // tie with the flag: steals voice 2
    send_alloc(1, 0, 1'b0);     // priority zero, no flag: nothing can go
    send_alloc(1, 0, 1'b1);     // steals the zero-priority voice
    send_alloc(3, 255, 1'b0);   // top priority beats a lower one of its type
    send_alloc(4, 255, 1'b1);   // type 4 holds voice 4 at 128
    send_alloc(6, 9, 1'b1);     // below the type-6 voice: refused
    send_release(5);
    send_release(5);            // already idle
    send_alloc(7, 77, 1'b0);    // takes the freed voice
    send_release(0);
    send_release(7);
    wait_idle();
  endtask

  // Reservation extremes: oversized ranges cut at the last voice, ranges that
  // start past it, and a reservation held only by the top type.
  task automatic test_reserved_ranges();
    write_reserved(32'hFFFF_FFFF);
    send_alloc(0, 50, 1'b1);    // range clipped to all voices
    send_alloc(1, 255, 1'b1);   // range starts at 15: empty
    send_alloc(6, 255, 1'b1);   // own range starts at 90: empty
    wait_idle();
    write_reserved(32'h8000_0000);
    send_alloc(7, 3, 1'b0);
    send_alloc(2, 255, 1'b1);   // pool starts at 8: empty
    wait_idle();
    write_reserved(32'h0000_0021);
    send_alloc(0, 100, 1'b0);
    send_alloc(1, 100, 1'b0);
    send_alloc(5, 100, 1'b0);   // shared pool from voice 3 on
    wait_idle();
  endtask

  // Mixed allocate/release traffic under three kinds of reservation setting.
  task automatic test_random_traffic(input int idle_pct, input int per_setting);
    logic [CFG_W-1:0] setting;
    int               prio;
    send_idle_pct = idle_pct;
    for (int kind = 0; kind < 3; kind++) begin
      setting = '0;
      for (int t = 0; t < NT; t++) begin
        case (kind)
          0:       setting[RES_W*t +: RES_W] = RES_W'($urandom_range(2));
          1:       setting[RES_W*t +: RES_W] =
                     ($urandom_range(3) == 0) ? RES_W'($urandom_range(15)) : '0;
          default: setting[RES_W*t +: RES_W] = RES_W'($urandom());
        endcase
      end
      write_reserved(setting);
      for (int n = 0; n < per_setting; n++) begin
        if ($urandom_range(99) < 30) begin
          send_release($urandom_range(NV-1));
        end else begin
          // bias toward a few low priorities so ties and zero show up often
          prio = ($urandom_range(2) == 0) ? $urandom_range(3) : $urandom_range(255);
          send_alloc($urandom_range(NT-1), prio, 1'($urandom()));
        end
      end
      wait_idle();
    end
  endtask

  initial begin
    rst_n               <= 1'b0;
    start               <= 1'b0;
    in_func             <= FUNC_ALLOC;
    in_clip_type        <= '0;
    in_request_priority <= '0;
    in_interrupt_equal  <= 1'b0;
    in_release_voice    <= '0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    errors        = 0;
    send_idle_pct = 0;
    n_granted     = 0;
    n_stolen      = 0;
    n_refused     = 0;
    n_released    = 0;
    n_settings    = 0;
    reserve_reg   = '0;
    for (int i = 0; i < NV; i++) begin
      voice_in_use[i] = 1'b0;
      voice_prio[i]   = '0;
      voice_kind[i]   = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_shared_pool();
    test_reserved_ranges();
    test_random_traffic(21, 200);
    test_random_traffic(47, 200);
    test_random_traffic(0, 200);

    $display("covered %0d releases and %0d allocations over %0d reservation settings:",
             n_released, n_granted + n_refused, n_settings);
    $display("  %0d granted (%0d by stealing), %0d refused", n_granted, n_stolen, n_refused);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

### sim.f
sv/ava_pkg.sv
sv/ava_ram.sv
sv/audio_voice_allocator.sv
sv/ava_checker.sv
test/testbench.sv
